/* src/dse_pkg.sv */
`default_nettype none

package dse_pkg;

   // Field widths of the stream payload and the registers.
   localparam int WEIGHT_W      = 16;
   localparam int TARGET_W      = 16;
   localparam int INTERVAL_W    = 16;
   localparam int ERR_W         = 17;
   localparam int ENTRIES_W     = 4;
   localparam int MEAN_W        = 21;
   localparam int DISP_W        = 20;
   localparam int TOTAL_W       = 32;
   localparam int FRAC_W        = 4;
   localparam int REQ_DATA_W    = 16;
   localparam int RSP_DATA_W    = 176;

   // Defaults.
   localparam int HISTORY_DEPTH_DEF = 10;
   localparam logic [TARGET_W-1:0]   TARGET_RST   = '0;
   localparam logic [INTERVAL_W-1:0] INTERVAL_RST = 16'd10;

   // Register map.
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_WEIGHT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SAVE_INTERVAL = 1'b1;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_UPDATE,
      ST_START,
      ST_DIVIDE,
      ST_RESULT
   } ctrl_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic read;
      logic update;
      logic start;
      logic finish;
   } dse_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic div_done;
   } dse_status_type;

endpackage

`default_nettype wire

/* src/dosing_error_statistics.sv */
`default_nettype none

// Dosing error statistics. Each request transaction carries the final weight
// of one finished dose and yields exactly one response transaction. When the
// target weight register is nonzero the dose is recorded: its weight and its
// error against the target enter a ring of the last HISTORY_DEPTH doses, and
// the cumulative dose, gram, target and error totals advance (all wrap at 32
// bits). The response reports the window weight sum and entry count, the
// window mean error in grams with 4 fraction bits (truncated toward zero,
// zero when the window is empty), the totals, and a save-due flag every
// save_interval recorded doses. One dose is handled at a time: a ring read
// and update, then the bit-serial divider that reduces the dose count by the
// save interval (the mean divider runs alongside it and finishes sooner),
// then the result is registered. The ring needs no clearing pass after
// reset; its entries only count once the window is full. Configuration must
// be written through the csr_ port while no dose is in flight; the block
// itself does not enforce this.
module dosing_error_statistics #(
   parameter int HISTORY_DEPTH = dse_pkg::HISTORY_DEPTH_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // [15:0] final_weight
   input  wire logic [dse_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // [0] recorded, [1] save_due, [5:2] entries_held, [26:6] mean_error_q4,
   // [46:27] window_dispensed, [78:47] dose_total, [110:79] grams_total,
   // [142:111] target_total, [174:143] error_total, [175] zero
   output logic      [dse_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  wire logic                             csr_we,
   input  wire logic [dse_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [dse_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   dse_pkg::dse_cmd_type    cmd;
   dse_pkg::dse_status_type status;

   // Sequencer.
   dse_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // Ring, sums, totals and dividers.
   dse_datapath #(
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_tdata),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_data  (rsp_tdata)
   );

`ifndef ASSERT_OFF
   // Only one dose is in flight: the block never offers a result while open for input.
   assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("request and response sides active together");

   // A dose that was not recorded can never raise the save flag.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tdata[0]) |-> !rsp_tdata[1])
      else $error("save_due without a recorded dose");

   // Once a response transaction completes, the block takes the next dose.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready) |=> req_tready)
      else $error("not ready after response transaction");

   // A newly accepted dose never produces a response in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !rsp_tvalid)
      else $error("response too early after request transaction");
`endif

endmodule

`default_nettype wire

/* src/dse_ram.sv */
`default_nettype none

module dse_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

/* src/dse_div.sv */
`default_nettype none

module dse_div #(
   parameter int DVD_W = 32,
   parameter int DVS_W = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [DVD_W-1:0] dividend,
   input  wire logic [DVS_W-1:0] divisor,
   output logic      [DVD_W-1:0] quotient,
   output logic      [DVS_W-1:0] remainder,
   output logic                  done
);

   localparam int CNT_W = $clog2(DVD_W + 1);

   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DVS_W:0]   shifted;
   logic [DVS_W:0]   diff;
   logic             fits;

   // One restoring step: bring down the next dividend bit and try a subtract.
   assign shifted = {rem_ff, quo_ff[DVD_W-1]};
   assign diff    = shifted - {1'b0, divisor};
   assign fits    = shifted >= {1'b0, divisor};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         cnt_in  = CNT_W'(DVD_W);
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DVD_W-2:0], fits};
         rem_in = fits ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign quotient  = quo_ff;
   assign remainder = rem_ff;
   assign done      = done_ff;

endmodule

`default_nettype wire

/* src/dse_datapath.sv */
`default_nettype none

module dse_datapath #(
   parameter int HISTORY_DEPTH = dse_pkg::HISTORY_DEPTH_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire dse_pkg::dse_cmd_type              cmd,
   output dse_pkg::dse_status_type                status,
   input  wire logic [dse_pkg::REQ_DATA_W-1:0]    req_data,
   input  wire logic                              csr_we,
   input  wire logic [dse_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [dse_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output logic      [dse_pkg::RSP_DATA_W-1:0]    rsp_data
);

   localparam int SLOT_W  = $clog2(HISTORY_DEPTH);
   localparam int CNT_W   = $clog2(HISTORY_DEPTH + 1);
   localparam int ESUM_W  = dse_pkg::ERR_W + $clog2(HISTORY_DEPTH);
   localparam int WSUM_W  = dse_pkg::WEIGHT_W + $clog2(HISTORY_DEPTH);
   localparam int NUM_W   = ESUM_W + dse_pkg::FRAC_W;
   localparam int ENT_X_W = (CNT_W > dse_pkg::ENTRIES_W) ? CNT_W : dse_pkg::ENTRIES_W;
   localparam int WS_X_W  = (WSUM_W > dse_pkg::DISP_W) ? WSUM_W : dse_pkg::DISP_W;
   localparam int MN_X_W  = (NUM_W > dse_pkg::MEAN_W) ? NUM_W : dse_pkg::MEAN_W;
   localparam int ENTRY_W = dse_pkg::ERR_W + dse_pkg::WEIGHT_W;
   localparam int TW      = dse_pkg::TOTAL_W;
   localparam int PAD_W   = dse_pkg::RSP_DATA_W - (2 + dse_pkg::ENTRIES_W + dse_pkg::MEAN_W
                                                   + dse_pkg::DISP_W + 4 * TW);

   // Configuration registers.
   logic [dse_pkg::TARGET_W-1:0]   target_ff, target_in;
   logic [dse_pkg::INTERVAL_W-1:0] interval_ff, interval_in;

   // Item and window state.
   logic [dse_pkg::WEIGHT_W-1:0]   weight_ff;
   logic                           rec_ff, rec_in;
   logic [SLOT_W-1:0]              slot_ff, slot_in;
   logic [CNT_W-1:0]               fill_ff, fill_in;
   logic signed [ESUM_W-1:0]       esum_ff, esum_in;
   logic [WSUM_W-1:0]              wsum_ff, wsum_in;
   logic [TW-1:0]                  dose_ff, dose_in;
   logic [TW-1:0]                  grams_ff, grams_in;
   logic [TW-1:0]                  tgt_ff, tgt_in;
   logic [TW-1:0]                  errc_ff, errc_in;
   logic                           due_ff;
   logic [dse_pkg::MEAN_W-1:0]     mean_ff;

   logic signed [dse_pkg::ERR_W-1:0] err;
   logic signed [dse_pkg::ERR_W-1:0] old_err;
   logic [dse_pkg::WEIGHT_W-1:0]     old_w;
   logic                             full;
   logic [ENTRY_W-1:0]               ram_rdata;

   logic signed [NUM_W-1:0]          num;
   logic [NUM_W-1:0]                 mag;
   logic [NUM_W-1:0]                 mean_quo;
   logic [CNT_W-1:0]                 mean_rem;
   logic                             mean_done;
   logic [TW-1:0]                    mod_quo;
   logic [dse_pkg::INTERVAL_W-1:0]   mod_rem;
   logic                             mod_done;
   logic signed [NUM_W-1:0]          mean_s;
   logic signed [MN_X_W-1:0]         mean_x;
   logic [ENT_X_W-1:0]               ent_x;
   logic [WS_X_W-1:0]                wsum_x;

   // Configuration write decode.
   always_comb begin
      target_in   = target_ff;
      interval_in = interval_ff;
      if (csr_we) begin
         unique case (csr_index)
            dse_pkg::CSR_TARGET_WEIGHT: target_in   = csr_wdata;
            dse_pkg::CSR_SAVE_INTERVAL: interval_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // History ring: error in the upper bits, weight in the lower bits.
   dse_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (HISTORY_DEPTH)
   ) u_ring (
      .clock (clock),
      .we    (cmd.update & rec_ff),
      .waddr (slot_ff),
      .wdata ({err, weight_ff}),
      .re    (cmd.read),
      .raddr (slot_ff),
      .rdata (ram_rdata)
   );

   // The slot being overwritten only counts once the window is full.
   assign full    = fill_ff == CNT_W'(HISTORY_DEPTH);
   assign err     = $signed({1'b0, weight_ff}) - $signed({1'b0, target_ff});
   assign old_err = full ? $signed(ram_rdata[ENTRY_W-1:dse_pkg::WEIGHT_W]) : '0;
   assign old_w   = full ? ram_rdata[dse_pkg::WEIGHT_W-1:0] : '0;

   // Window sums and cumulative totals after a recorded dose.
   always_comb begin
      rec_in   = rec_ff;
      slot_in  = slot_ff;
      fill_in  = fill_ff;
      esum_in  = esum_ff;
      wsum_in  = wsum_ff;
      dose_in  = dose_ff;
      grams_in = grams_ff;
      tgt_in   = tgt_ff;
      errc_in  = errc_ff;
      if (cmd.capture) begin
         rec_in = target_ff != '0;
      end
      if (cmd.update && rec_ff) begin
         slot_in  = (slot_ff == SLOT_W'(HISTORY_DEPTH - 1)) ? '0 : slot_ff + 1'b1;
         fill_in  = full ? fill_ff : fill_ff + 1'b1;
         esum_in  = esum_ff + ESUM_W'(err) - ESUM_W'(old_err);
         wsum_in  = wsum_ff + WSUM_W'(weight_ff) - WSUM_W'(old_w);
         dose_in  = dose_ff + 1'b1;
         grams_in = grams_ff + TW'(weight_ff);
         tgt_in   = tgt_ff + TW'(target_ff);
         errc_in  = errc_ff + TW'(err);
      end
   end

   // Magnitude of the scaled error sum feeds the unsigned divider.
   assign num = esum_ff <<< dse_pkg::FRAC_W;
   assign mag = esum_ff[ESUM_W-1] ? NUM_W'(-num) : NUM_W'(num);

   dse_div #(
      .DVD_W (NUM_W),
      .DVS_W (CNT_W)
   ) u_mean_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.start),
      .dividend  (mag),
      .divisor   (fill_ff),
      .quotient  (mean_quo),
      .remainder (mean_rem),
      .done      (mean_done)
   );

   // Remainder of the dose count by the save interval.
   dse_div #(
      .DVD_W (TW),
      .DVS_W (dse_pkg::INTERVAL_W)
   ) u_save_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.start),
      .dividend  (dose_ff),
      .divisor   (interval_ff),
      .quotient  (mod_quo),
      .remainder (mod_rem),
      .done      (mod_done)
   );

   assign status.div_done = mean_done & mod_done;

   // Restore the sign; truncation toward zero falls out of the magnitude divide.
   assign mean_s = esum_ff[ESUM_W-1] ? -$signed(mean_quo) : $signed(mean_quo);
   assign mean_x = MN_X_W'(mean_s);

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff   <= dse_pkg::TARGET_RST;
         interval_ff <= dse_pkg::INTERVAL_RST;
         rec_ff      <= 1'b0;
         slot_ff     <= '0;
         fill_ff     <= '0;
         esum_ff     <= '0;
         wsum_ff     <= '0;
         dose_ff     <= '0;
         grams_ff    <= '0;
         tgt_ff      <= '0;
         errc_ff     <= '0;
      end else begin
         target_ff   <= target_in;
         interval_ff <= interval_in;
         rec_ff      <= rec_in;
         slot_ff     <= slot_in;
         fill_ff     <= fill_in;
         esum_ff     <= esum_in;
         wsum_ff     <= wsum_in;
         dose_ff     <= dose_in;
         grams_ff    <= grams_in;
         tgt_ff      <= tgt_in;
         errc_ff     <= errc_in;
      end
      if (cmd.capture) begin
         weight_ff <= req_data[dse_pkg::WEIGHT_W-1:0];
      end
      if (cmd.finish) begin
         due_ff  <= rec_ff && (interval_ff != '0) && (mod_rem == '0);
         mean_ff <= (fill_ff == '0) ? '0 : mean_x[dse_pkg::MEAN_W-1:0];
      end
   end

   // Result packing, highest field first.
   assign ent_x  = ENT_X_W'(fill_ff);
   assign wsum_x = WS_X_W'(wsum_ff);

   assign rsp_data = {{PAD_W{1'b0}}, errc_ff, tgt_ff, grams_ff, dose_ff,
                      wsum_x[dse_pkg::DISP_W-1:0], mean_ff,
                      ent_x[dse_pkg::ENTRIES_W-1:0], due_ff, rec_ff};

endmodule

`default_nettype wire

/* src/dse_ctrl.sv */
`default_nettype none

module dse_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   input  wire dse_pkg::dse_status_type status,
   output dse_pkg::dse_cmd_type         cmd
);

   dse_pkg::ctrl_state_type state_ff, state_in;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dse_pkg::ST_IDLE:   if (req_tvalid) state_in = dse_pkg::ST_READ;
         dse_pkg::ST_READ:   state_in = dse_pkg::ST_UPDATE;
         dse_pkg::ST_UPDATE: state_in = dse_pkg::ST_START;
         dse_pkg::ST_START:  state_in = dse_pkg::ST_DIVIDE;
         dse_pkg::ST_DIVIDE: if (status.div_done) state_in = dse_pkg::ST_RESULT;
         dse_pkg::ST_RESULT: if (rsp_tready) state_in = dse_pkg::ST_IDLE;
         default:            state_in = dse_pkg::ST_IDLE;
      endcase
   end

   // Handshake and datapath commands.
   always_comb begin
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         dse_pkg::ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
         end
         dse_pkg::ST_READ:   cmd.read   = 1'b1;
         dse_pkg::ST_UPDATE: cmd.update = 1'b1;
         dse_pkg::ST_START:  cmd.start  = 1'b1;
         dse_pkg::ST_DIVIDE: cmd.finish = status.div_done;
         dse_pkg::ST_RESULT: rsp_tvalid = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dse_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

/* verif/tb_dosing_error_statistics.sv */
`timescale 1ns / 100ps

module tb_dosing_error_statistics;
   import dse_pkg::*;

   localparam int HIST_DEPTH  = HISTORY_DEPTH_DEF;
   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 400;

   // One response transaction, packed in the same bit order as rsp_tdata.
   typedef struct packed {
      logic [TOTAL_W-1:0]   error_total;
      logic [TOTAL_W-1:0]   target_total;
      logic [TOTAL_W-1:0]   grams_total;
      logic [TOTAL_W-1:0]   dose_total;
      logic [DISP_W-1:0]    window_dispensed;
      logic [MEAN_W-1:0]    mean_error_q4;
      logic [ENTRIES_W-1:0] entries_held;
      logic                 save_due;
      logic                 recorded;
   } dose_result_t;

   typedef enum logic [1:0] {
      ROW_DOSE,
      ROW_TARGET,
      ROW_INTERVAL
   } row_kind_t;

   typedef struct {
      row_kind_t        kind;
      logic [15:0]      value;
      bit               typed;
      dose_result_t     result;
   } plan_row_t;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   dosing_error_statistics #(
      .HISTORY_DEPTH(HIST_DEPTH)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // Clock with a 10 ns period.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predictor copy of the registers and the dose history.
   logic [TARGET_W-1:0]          cfg_target   = TARGET_RST;
   logic [INTERVAL_W-1:0]        cfg_interval = INTERVAL_RST;
   logic signed [ERR_W-1:0]      err_ring [HIST_DEPTH];
   logic [WEIGHT_W-1:0]          weight_ring [HIST_DEPTH];
   int unsigned                  ring_slot = 0;
   int unsigned                  ring_fill = 0;
   longint                       win_err_sum = 0;
   longint                       win_weight_sum = 0;
   logic [TOTAL_W-1:0]           dose_cnt = '0;
   logic [TOTAL_W-1:0]           gram_cnt = '0;
   logic [TOTAL_W-1:0]           target_cnt = '0;
   logic [TOTAL_W-1:0]           err_cnt = '0;

   dose_result_t                 pending_results [$];
   int                           error_count = 0;
   int                           result_count = 0;
   int                           cycle_count = 0;
   int                           idle_pct = 0;
   int                           stall_pct = 0;
   int                           hold_ask = 0;
   int                           hold_seen = 0;
   int                           hold_left = 0;

   // Records one dose against the current registers and returns its statistics.
   function automatic dose_result_t predict_dose(input logic [WEIGHT_W-1:0] weight);
      dose_result_t r;
      int           err;
      longint       es;
      longint       ws;
      longint       mean;
      r = '0;
      mean = 0;
      if (cfg_target != 0) begin
         err = int'(weight) - int'(cfg_target);
         err_ring[ring_slot] = err[ERR_W-1:0];
         weight_ring[ring_slot] = weight;
         ring_slot = (ring_slot + 1) % HIST_DEPTH;
         if (ring_fill < HIST_DEPTH)
            ring_fill++;
         dose_cnt = dose_cnt + 1;
         gram_cnt = gram_cnt + weight;
         target_cnt = target_cnt + cfg_target;
         err_cnt = err_cnt + err;
         r.recorded = 1'b1;
         if (cfg_interval != 0 && (dose_cnt % cfg_interval) == 0)
            r.save_due = 1'b1;
         es = 0;
         ws = 0;
         for (int i = 0; i < ring_fill; i++) begin
            es += err_ring[i];
            ws += weight_ring[i];
         end
         win_err_sum = es;
         win_weight_sum = ws;
      end
      // Signed division truncates toward zero, as the block does.
      if (ring_fill != 0)
         mean = (win_err_sum * 16) / longint'(ring_fill);
      r.entries_held     = ring_fill[ENTRIES_W-1:0];
      r.mean_error_q4    = mean[MEAN_W-1:0];
      r.window_dispensed = win_weight_sum[DISP_W-1:0];
      r.dose_total       = dose_cnt;
      r.grams_total      = gram_cnt;
      r.target_total     = target_cnt;
      r.error_total      = err_cnt;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("MISMATCH response %0d %s: got %h, expected %h", result_count, what, got,
               want);
      error_count++;
   endtask

   task automatic check_field(input string what, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         report_mismatch(what, got, want);
   endtask

   // Offers one dose transaction and books its expected statistics on acceptance.
   task automatic send_weight(input logic [WEIGHT_W-1:0] weight, input bit typed,
                              input dose_result_t typed_result);
      dose_result_t r;
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= weight;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      r = predict_dose(weight);
      pending_results.push_back(typed ? typed_result : r);
   endtask

   // Stops offering doses and waits until every response has come back.
   task automatic wait_idle(input int settle);
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      if (index == CSR_TARGET_WEIGHT)
         cfg_target = value;
      else
         cfg_interval = value;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Picks a new target and save interval between phases, extremes included.
   task automatic shuffle_config;
      logic [15:0] t;
      logic [15:0] n;
      case ($urandom_range(7))
         0:       t = '0;
         1:       t = 16'hFFFF;
         2:       t = 16'd1;
         default: t = 16'($urandom_range(1, 65535));
      endcase
      case ($urandom_range(5))
         0:       n = '0;
         1:       n = 16'hFFFF;
         2:       n = 16'($urandom_range(0, 65535));
         default: n = 16'($urandom_range(1, 12));
      endcase
      wait_idle(4);
      write_reg(CSR_TARGET_WEIGHT, t);
      write_reg(CSR_SAVE_INTERVAL, n);
   endtask

   // Weights near the target in four of ten picks, with the field extremes and full-range noise.
   function automatic logic [WEIGHT_W-1:0] pick_weight;
      int w;
      case ($urandom_range(9))
         0: w = 0;
         1: w = 65535;
         2, 3, 4, 5: begin
            w = int'(cfg_target) + int'($urandom_range(200)) - 100;
            if (w < 0)
               w = 0;
            if (w > 65535)
               w = 65535;
         end
         default: w = int'($urandom_range(65535));
      endcase
      return w[WEIGHT_W-1:0];
   endfunction

   task automatic run_phase(input int doses, input int sender_idle, input int rx_stall);
      idle_pct  = sender_idle;
      stall_pct = rx_stall;
      for (int i = 0; i < doses; i++)
         send_weight(pick_weight(), 1'b0, '0);
   endtask

   // Directed doses and register writes. Rows with typed results are checked
   // against the values given here; the rest go through the predictor.
   plan_row_t dose_plan [$] = '{
      '{ROW_DOSE,     16'd1234,  1'b1, '0},
      '{ROW_DOSE,     16'd65535, 1'b1, '0},
      '{ROW_TARGET,   16'd100,   1'b0, '0},
      '{ROW_DOSE,     16'd0,     1'b1, '{error_total: -32'sd100, target_total: 32'd100,
                                         grams_total: 32'd0, dose_total: 32'd1,
                                         window_dispensed: 20'd0,
                                         mean_error_q4: -21'sd1600, entries_held: 4'd1,
                                         save_due: 1'b0, recorded: 1'b1}},
      '{ROW_DOSE,     16'd65535, 1'b0, '0},
      '{ROW_DOSE,     16'd100,   1'b0, '0},
      '{ROW_DOSE,     16'd99,    1'b0, '0},
      '{ROW_DOSE,     16'd101,   1'b0, '0},
      '{ROW_DOSE,     16'd1,     1'b0, '0},
      '{ROW_DOSE,     16'd32768, 1'b0, '0},
      '{ROW_DOSE,     16'd200,   1'b0, '0},
      '{ROW_DOSE,     16'd50,    1'b0, '0},
      '{ROW_DOSE,     16'd150,   1'b0, '0},
      '{ROW_DOSE,     16'd65534, 1'b0, '0},
      '{ROW_INTERVAL, 16'd1,     1'b0, '0},
      '{ROW_TARGET,   16'd65535, 1'b0, '0},
      '{ROW_DOSE,     16'd0,     1'b0, '0},
      '{ROW_DOSE,     16'd65535, 1'b0, '0},
      '{ROW_DOSE,     16'd0,     1'b0, '0},
      '{ROW_INTERVAL, 16'd65535, 1'b0, '0},
      '{ROW_DOSE,     16'd12345, 1'b0, '0},
      '{ROW_INTERVAL, 16'd0,     1'b0, '0},
      '{ROW_DOSE,     16'd7,     1'b0, '0},
      '{ROW_TARGET,   16'd0,     1'b0, '0},
      '{ROW_DOSE,     16'd500,   1'b0, '0},
      '{ROW_TARGET,   16'd1,     1'b0, '0},
      '{ROW_DOSE,     16'd0,     1'b0, '0}
   };

   // Main sequence: reset, directed rows, random phases, then the verdict.
   initial begin
      for (int i = 0; i < HIST_DEPTH; i++) begin
         err_ring[i]    = '0;
         weight_ring[i] = '0;
      end
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dose_plan[i]) begin
         case (dose_plan[i].kind)
            ROW_DOSE:
               send_weight(dose_plan[i].value, dose_plan[i].typed, dose_plan[i].result);
            ROW_TARGET: begin
               wait_idle(4);
               write_reg(CSR_TARGET_WEIGHT, dose_plan[i].value);
            end
            default: begin
               wait_idle(4);
               write_reg(CSR_SAVE_INTERVAL, dose_plan[i].value);
            end
         endcase
      end

      shuffle_config();
      run_phase(85, 0, 0);
      shuffle_config();
      run_phase(85, 47, 0);
      shuffle_config();
      run_phase(85, 0, 47);
      shuffle_config();
      run_phase(85, 30, 30);

      // Long receiver hold-off while doses keep coming, so the input backs up.
      shuffle_config();
      hold_ask++;
      run_phase(60, 0, 0);

      wait_idle(50);
      if (error_count == 0)
         $display("tb_dosing_error_statistics: done, clean");
      else
         $display("tb_dosing_error_statistics: done, errors");
      $finish;
   end

   // Response ready, with random stalls and one long hold-off.
   always @(negedge clock) begin
      if (hold_ask != hold_seen) begin
         hold_seen  <= hold_ask;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Compares each response transaction with the oldest expectation.
   always @(posedge clock) begin
      dose_result_t got;
      dose_result_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[$bits(dose_result_t)-1:0];
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected response", got.dose_total, '0);
         end else begin
            want = pending_results.pop_front();
            check_field("recorded", 32'(got.recorded), 32'(want.recorded));
            check_field("save_due", 32'(got.save_due), 32'(want.save_due));
            check_field("entries_held", 32'(got.entries_held), 32'(want.entries_held));
            check_field("mean_error_q4", 32'(got.mean_error_q4), 32'(want.mean_error_q4));
            check_field("window_dispensed", 32'(got.window_dispensed),
                        32'(want.window_dispensed));
            check_field("dose_total", got.dose_total, want.dose_total);
            check_field("grams_total", got.grams_total, want.grams_total);
            check_field("target_total", got.target_total, want.target_total);
            check_field("error_total", got.error_total, want.error_total);
         end
         result_count++;
      end
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout with %0d responses outstanding", pending_results.size());
         $display("tb_dosing_error_statistics: done, errors");
         $finish;
      end
   end

endmodule
